[hdl/pnom_pkg.sv]
package pnom_pkg;

    typedef enum logic [1:0] {
        OP_NOTE_ON  = 2'd0,
        OP_NOTE_OFF = 2'd1,
        OP_TICK     = 2'd2
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DRAIN,
        ST_SCALE,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic note_on;
        logic note_off;
        logic start;
        logic issue;
        logic scale;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic last_voice;
        logic pipe_empty;
        logic out_free;
    } stat_t;

    localparam int SINE_BITS = 15;
    localparam int VEL_BITS = 7;
    localparam logic [15:0] GAIN_RESET = 16'd103;

    localparam longint Q30_ONE = 64'sd1073741824;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint SINE_PEAK = 64'sd32767;
    localparam longint SINE_ROUND = Q30_ONE / 2;
    localparam longint unsigned INC_ROUND = 64'd600 << 20;
    localparam longint unsigned INC_DIV = 64'd1200 << 20;

    localparam longint unsigned SEMITONE_RATIO_Q30 [12] = '{
        64'd1073741824, 64'd1137589835, 64'd1205234447, 64'd1276901417,
        64'd1352829926, 64'd1433273380, 64'd1518500250, 64'd1608794974,
        64'd1704458901, 64'd1805811301, 64'd1913190429, 64'd2026954652
    };

    // round(32767 * sin(pi/2 * r / 2^qbits)), taylor series in q30
    function automatic longint quarter_sine(input longint r, input int qbits);
        longint u;
        longint th;
        longint th2;
        longint term;
        longint sum;
        longint v;
        u = r <<< (30 - qbits);
        th = (u * HALF_PI_Q30) >>> 30;
        th2 = (th * th) >>> 30;
        term = th;
        sum = th;
        term = ((term * th2) >>> 30) / 6;
        sum = sum - term;
        term = ((term * th2) >>> 30) / 20;
        sum = sum + term;
        term = ((term * th2) >>> 30) / 42;
        sum = sum - term;
        term = ((term * th2) >>> 30) / 72;
        sum = sum + term;
        term = ((term * th2) >>> 30) / 110;
        sum = sum - term;
        term = ((term * th2) >>> 30) / 156;
        sum = sum + term;
        if (sum < 0)
        begin
            sum = 0;
        end
        v = (sum * SINE_PEAK + SINE_ROUND) >>> 30;
        if (v > SINE_PEAK)
        begin
            v = SINE_PEAK;
        end
        return v;
    endfunction

    // equal-tempered increment, a4 = 440 hz at 48 khz
    function automatic longint unsigned phase_increment(input int note, input int pbits);
        int d;
        int oct;
        int c;
        int sh;
        longint unsigned v;
        d = note - 69;
        oct = (d >= 0) ? d / 12 : -((-d + 11) / 12);
        c = d - 12 * oct;
        sh = pbits + oct - 10;
        if (sh < 0)
        begin
            sh = 0;
        end
        v = (SEMITONE_RATIO_Q30[c] * 64'd11) << sh;
        v = (v + INC_ROUND) / INC_DIV;
        return v & ((64'd1 << pbits) - 64'd1);
    endfunction

endpackage

[hdl/pnom_if.sv]
interface pnom_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [6:0] note;
    logic [6:0] velocity;

    modport source (output valid, output operation, output note, output velocity,
                    input ready);
    modport sink (input valid, input operation, input note, input velocity,
                  output ready);
endinterface

interface pnom_smp_if #(parameter int SAMPLE_BITS = 16);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

[hdl/pnom_ram.sv]
module pnom_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[hdl/pnom_ctrl.sv]
module pnom_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [1:0]        operation,
    output logic              in_ready,
    input  pnom_pkg::stat_t   stat,
    output pnom_pkg::cmd_t    cmd
);

    pnom_pkg::state_t state_reg;
    pnom_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pnom_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready = 1'b0;
        cmd = '0;
        case (state_reg)
            pnom_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    case (operation)
                        pnom_pkg::OP_NOTE_ON:  cmd.note_on = 1'b1;
                        pnom_pkg::OP_NOTE_OFF: cmd.note_off = 1'b1;
                        pnom_pkg::OP_TICK:
                        begin
                            cmd.start = 1'b1;
                            state_next = pnom_pkg::ST_WALK;
                        end
                        default: ;
                    endcase
                end
            end
            pnom_pkg::ST_WALK:
            begin
                cmd.issue = 1'b1;
                if (stat.last_voice)
                begin
                    state_next = pnom_pkg::ST_DRAIN;
                end
            end
            pnom_pkg::ST_DRAIN:
            begin
                if (stat.pipe_empty)
                begin
                    state_next = pnom_pkg::ST_SCALE;
                end
            end
            pnom_pkg::ST_SCALE:
            begin
                cmd.scale = 1'b1;
                state_next = pnom_pkg::ST_OUT;
            end
            pnom_pkg::ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next = pnom_pkg::ST_IDLE;
                end
            end
            default: state_next = pnom_pkg::ST_IDLE;
        endcase
    end

endmodule

[hdl/pnom_dp.sv]
module pnom_dp #(
    parameter int VOICE_COUNT = 128,
    parameter int PHASE_BITS = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  pnom_pkg::cmd_t                cmd,
    output pnom_pkg::stat_t               stat,
    input  logic [6:0]                    note,
    input  logic [6:0]                    velocity,
    input  logic                          cfg_write,
    input  logic [15:0]                   cfg_data,
    input  logic                          out_ready,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] out_sample
);

    localparam int VA = $clog2(VOICE_COUNT > 1 ? VOICE_COUNT : 2);
    localparam int VB = pnom_pkg::VEL_BITS;
    localparam int SB = pnom_pkg::SINE_BITS;
    localparam int RAM_W = VB + PHASE_BITS;
    localparam int QB = SINE_ADDR_BITS - 2;
    localparam int QTR = 1 << QB;
    localparam int PROD_BITS = SB + VB + 1;
    localparam int SUM_BITS = PROD_BITS + $clog2(VOICE_COUNT > 1 ? VOICE_COUNT : 2);
    localparam int SCL_BITS = SUM_BITS + 17;
    localparam int SHB = SCL_BITS - 16;
    localparam logic signed [SHB-1:0] SAT_HI = SHB'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [SHB-1:0] SAT_LO = SHB'(-(64'sd1 <<< (SAMPLE_BITS - 1)));

    // constant tables built at elaboration
    logic [PHASE_BITS-1:0] inc_rom [VOICE_COUNT];
    logic [SB-1:0]         qsine_rom [QTR+1];

    for (genvar g = 0; g < VOICE_COUNT; g++)
    begin : g_inc
        assign inc_rom[g] = PHASE_BITS'(pnom_pkg::phase_increment(g, PHASE_BITS));
    end

    for (genvar g = 0; g <= QTR; g++)
    begin : g_sine
        assign qsine_rom[g] = SB'(pnom_pkg::quarter_sine(64'(g), QB));
    end

    logic [15:0]              gain_reg;
    logic [VOICE_COUNT-1:0]   active_reg;
    logic [VA-1:0]            vidx_reg;
    logic                     s1_valid_reg;
    logic                     s1_act_reg;
    logic [VA-1:0]            s1_idx_reg;
    logic                     s2_valid_reg;
    logic [SB-1:0]            s2_mag_reg;
    logic                     s2_neg_reg;
    logic [VB-1:0]            s2_vel_reg;
    logic                     s3_valid_reg;
    logic signed [PROD_BITS-1:0] s3_prod_reg;
    logic signed [SUM_BITS-1:0]  acc_reg;
    logic signed [SCL_BITS-1:0]  scaled_reg;
    logic                     out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_reg;
    logic signed [SAMPLE_BITS-1:0] out_sample_next;

    logic                     in_range;
    logic [VA-1:0]            note_idx;
    logic                     ram_we;
    logic [VA-1:0]            ram_waddr;
    logic [RAM_W-1:0]         ram_wdata;
    logic [RAM_W-1:0]         ram_rdata;
    logic [PHASE_BITS-1:0]    s1_phase;
    logic [VB-1:0]            s1_vel;
    logic [SINE_ADDR_BITS-1:0] s1_sidx;
    logic [QB:0]              s1_taddr;
    logic [SB+VB-1:0]         mag_prod;
    logic signed [SHB-1:0]    shifted;

    assign in_range = ({1'b0, note} < 8'(VOICE_COUNT));
    assign note_idx = note[VA-1:0];

    assign s1_phase = ram_rdata[PHASE_BITS-1:0];
    assign s1_vel = ram_rdata[RAM_W-1:PHASE_BITS];
    assign s1_sidx = s1_phase[PHASE_BITS-1 -: SINE_ADDR_BITS];
    // odd quadrants read the quarter table mirrored
    assign s1_taddr = s1_sidx[QB] ? ((QB+1)'(QTR) - {1'b0, s1_sidx[QB-1:0]})
                                  : {1'b0, s1_sidx[QB-1:0]};

    // note on clears the phase; only active voices advance during a walk
    always_comb
    begin
        if (cmd.note_on)
        begin
            ram_we = in_range;
            ram_waddr = note_idx;
            ram_wdata = {velocity, {PHASE_BITS{1'b0}}};
        end
        else
        begin
            ram_we = s1_valid_reg && s1_act_reg;
            ram_waddr = s1_idx_reg;
            ram_wdata = {s1_vel, s1_phase + inc_rom[s1_idx_reg]};
        end
    end

    pnom_ram #(
        .WIDTH (RAM_W),
        .DEPTH (VOICE_COUNT)
    ) u_voice_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (vidx_reg),
        .rdata (ram_rdata)
    );

    assign mag_prod = s2_mag_reg * s2_vel_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= pnom_pkg::GAIN_RESET;
            active_reg <= '0;
            vidx_reg <= '0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                gain_reg <= cfg_data;
            end
            if (cmd.note_on && in_range)
            begin
                active_reg[note_idx] <= 1'b1;
            end
            else if (cmd.note_off && in_range)
            begin
                active_reg[note_idx] <= 1'b0;
            end
            if (cmd.start)
            begin
                vidx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                vidx_reg <= vidx_reg + 1'b1;
            end
            s1_valid_reg <= cmd.issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        s1_act_reg <= active_reg[vidx_reg];
        s1_idx_reg <= vidx_reg;
        // inactive voices weigh zero, their stored data may be unwritten
        s2_mag_reg <= s1_act_reg ? qsine_rom[s1_taddr] : '0;
        s2_neg_reg <= s1_act_reg && s1_sidx[QB+1];
        s2_vel_reg <= s1_act_reg ? s1_vel : '0;
        s3_prod_reg <= s2_neg_reg ? -$signed({1'b0, mag_prod}) : $signed({1'b0, mag_prod});
        if (cmd.start)
        begin
            acc_reg <= '0;
        end
        else if (s3_valid_reg)
        begin
            acc_reg <= acc_reg + SUM_BITS'(s3_prod_reg);
        end
        if (cmd.scale)
        begin
            scaled_reg <= acc_reg * $signed({1'b0, gain_reg});
        end
        if (cmd.load_out)
        begin
            out_sample_reg <= out_sample_next;
        end
    end

    // floor shift by 16, then saturate
    assign shifted = $signed(scaled_reg[SCL_BITS-1:16]);

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            out_sample_next = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            out_sample_next = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            out_sample_next = shifted[SAMPLE_BITS-1:0];
        end
    end

    assign stat.last_voice = (vidx_reg == VA'(VOICE_COUNT - 1));
    assign stat.pipe_empty = !s1_valid_reg && !s2_valid_reg && !s3_valid_reg;
    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_sample = out_sample_reg;

endmodule

[hdl/polyphonic_note_oscillator_mixer.sv]
// polyphonic sine mixer, one voice per midi note
// request channel (valid/ready): operation, note, velocity
//   note on  - voice becomes active with the given velocity, phase restarts at zero
//   note off - voice goes quiet
//   tick     - walks all voices and yields one mixed sample on the result channel
// note on and note off give no result
// a tick runs a walk over all voices: the walk reads one
// voice per cycle from the voice memory, then a short pipeline drains,
// the sum is scaled by master_gain and saturated into the result register
// requests are taken one at a time; while a tick is being worked on request.ready is low
// the result register holds the sample until result.ready; a stalled receiver only
// delays the end of the next tick, note requests are still taken meanwhile
// cfg_write/cfg_data load master_gain, write it only while the block is idle
// reset clears all active voices and sets master_gain to 103; no memory sweep is needed
module polyphonic_note_oscillator_mixer #(
    parameter int VOICE_COUNT = 128,
    parameter int PHASE_BITS = 32,
    parameter int SINE_ADDR_BITS = 10,
    parameter int SAMPLE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    pnom_req_if.sink    request,
    pnom_smp_if.source  result,
    input  logic        cfg_write,
    input  logic [15:0] cfg_data
);

    pnom_pkg::cmd_t  cmd;
    pnom_pkg::stat_t stat;
    logic            in_ready;
    logic            out_valid;
    logic signed [SAMPLE_BITS-1:0] out_sample;

    pnom_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (request.valid),
        .operation (request.operation),
        .in_ready  (in_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    pnom_dp #(
        .VOICE_COUNT    (VOICE_COUNT),
        .PHASE_BITS     (PHASE_BITS),
        .SINE_ADDR_BITS (SINE_ADDR_BITS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .note       (request.note),
        .velocity   (request.velocity),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .out_ready  (result.ready),
        .out_valid  (out_valid),
        .out_sample (out_sample)
    );

    assign request.ready = in_ready;
    assign result.valid = out_valid;
    assign result.sample = out_sample;

    // a sample is never loaded over one not yet taken
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result.valid || result.ready))
        else $error("result overwritten before taken");

    // scaling starts only once every voice has reached the accumulator
    a_scale_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale |-> stat.pipe_empty)
        else $error("scale before pipeline drained");

    // the walk stops right after the last voice
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue && stat.last_voice) |=> !cmd.issue)
        else $error("walk ran past last voice");

    // no request is taken during the walk or the scale step of a tick
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.issue || cmd.scale) |-> !request.ready)
        else $error("request taken during tick");

endmodule
